>>> rtl/core/bld_pkg.sv
// bld_pkg: shared widths, opcode and status codes, and the cell control word
// used by the deque cells and the deque top level; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bld_pkg;

    localparam int DATA_W   = 32;
    localparam int OPCODE_W = 3;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 7;

    // opcodes of the input word
    localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_SEARCH     = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_DUMP       = 3'd4;

    // status codes of the result word
    localparam logic [STATUS_W-1:0] STS_DONE     = 3'd0;
    localparam logic [STATUS_W-1:0] STS_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] STS_EMPTY    = 3'd2;
    localparam logic [STATUS_W-1:0] STS_NOTFOUND = 3'd3;
    localparam logic [STATUS_W-1:0] STS_FOUND    = 3'd4;
    localparam logic [STATUS_W-1:0] STS_LISTED   = 3'd5;

    // per-cell control: load wins over shift, shift over rotate
    typedef struct packed {
        logic load;
        logic shift;
        logic rot;
    } cell_ctl_t;

endpackage

`default_nettype wire

>>> rtl/core/bounded_list_deque_with_search_unit.sv
// bounded_list_deque_with_search_unit: deque of signed words with linear search
// depends on bld_pkg and bld_cell
`timescale 1ns / 1ps
`default_nettype none

// The sequence lives in a chain of DEPTH cells in logical order, the front
// entry in cell 0. Push front shifts the whole chain one cell toward the back
// and loads the new word into cell 0; push back loads the cell at the current
// count; pop back only lowers the count. Search and dump rotate the chain one
// cell per cycle toward cell 0, but not while a result waits on out_ready,
// until it has turned through all DEPTH cells, so cell 0 sees every entry
// in order and the chain is back in place at the end. A push or pop passes
// through accept (idle) and execute (exec), and so does a search or dump on
// an empty store or an unused opcode. A dump of a non-empty store then
// rotates in the scan state, and such a search also passes the closing
// state; each step that writes a result waits while the result register is
// held by out_ready low. One item is in work at a time.
// A search holds each match back one step so that the final match can carry
// last_result. Results leave through a single output register that is
// refilled in the cycle it is taken.

module bounded_list_deque_with_search_unit
    import bld_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic        [OPCODE_W-1:0] opcode,
    input  wire logic signed [DATA_W-1:0]   value,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic             [STATUS_W-1:0] status,
    output logic             [POS_W-1:0]    position,
    output logic signed      [DATA_W-1:0]   element,
    output logic                            last_result
);

    localparam int KW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_FINISH
    } state_t;

    // control state
    state_t              state_reg,   state_next;
    logic [CW-1:0]       cnt_reg,     cnt_next;
    logic [KW-1:0]       k_reg,       k_next;
    logic                pend_v_reg,  pend_v_next;
    logic                out_v_reg,   out_v_next;

    // latched input word and held match
    logic [OPCODE_W-1:0] op_reg,      op_next;
    logic [DATA_W-1:0]   val_reg,     val_next;
    logic [POS_W-1:0]    pend_pos_reg, pend_pos_next;
    logic [DATA_W-1:0]   pend_el_reg, pend_el_next;

    // result register
    logic [STATUS_W-1:0] sts_reg,     sts_next;
    logic [POS_W-1:0]    pos_reg,     pos_next;
    logic [DATA_W-1:0]   el_reg,      el_next;
    logic                last_reg,    last_next;

    // chain controls
    logic                do_shift;
    logic                do_rot;
    logic                do_load_back;
    cell_ctl_t           ctl   [DEPTH];
    logic [DATA_W-1:0]   cdata [DEPTH];

    // scan helpers
    logic                slot_free;
    logic                in_list;
    logic                is_match;
    logic [POS_W-1:0]    k_pos;

    assign slot_free = !out_v_reg || out_ready;
    assign in_list   = CW'(k_reg) < cnt_reg;
    assign is_match  = (cdata[0] == val_reg);
    assign k_pos     = {{(POS_W-KW){1'b0}}, k_reg} + POS_W'(1);

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        k_next        = k_reg;
        pend_v_next   = pend_v_reg;
        op_next       = op_reg;
        val_next      = val_reg;
        pend_pos_next = pend_pos_reg;
        pend_el_next  = pend_el_reg;
        sts_next      = sts_reg;
        pos_next      = pos_reg;
        el_next       = el_reg;
        last_next     = last_reg;
        do_shift      = 1'b0;
        do_rot        = 1'b0;
        do_load_back  = 1'b0;

        // a taken result frees the register unless refilled below
        out_v_next = out_v_reg && !out_ready;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = opcode;
                    val_next   = value;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                if (op_reg inside {OP_PUSH_FRONT, OP_PUSH_BACK, OP_POP_BACK,
                                   OP_SEARCH, OP_DUMP})
                begin
                    if (op_reg inside {OP_SEARCH, OP_DUMP} && cnt_reg != '0)
                    begin
                        // no result yet, start the rotation
                        k_next      = '0;
                        pend_v_next = 1'b0;
                        state_next  = S_SCAN;
                    end
                    else if (slot_free)
                    begin
                        out_v_next = 1'b1;
                        pos_next   = '0;
                        el_next    = '0;
                        last_next  = 1'b1;
                        sts_next   = STS_DONE;
                        state_next = S_IDLE;
                        if (op_reg inside {OP_PUSH_FRONT, OP_PUSH_BACK})
                        begin
                            if (cnt_reg == CW'(DEPTH))
                            begin
                                sts_next = STS_FULL;
                            end
                            else
                            begin
                                do_shift     = (op_reg == OP_PUSH_FRONT);
                                do_load_back = (op_reg == OP_PUSH_BACK);
                                cnt_next     = cnt_reg + CW'(1);
                            end
                        end
                        else if (cnt_reg == '0)
                        begin
                            sts_next = STS_EMPTY;
                        end
                        else
                        begin
                            // pop back with entries present
                            cnt_next = cnt_reg - CW'(1);
                        end
                    end
                end
                else
                begin
                    // unknown opcode: no state change, no result
                    state_next = S_IDLE;
                end
            end

            S_SCAN:
            begin
                if (op_reg == OP_DUMP && in_list)
                begin
                    if (slot_free)
                    begin
                        out_v_next = 1'b1;
                        sts_next   = STS_LISTED;
                        pos_next   = k_pos;
                        el_next    = cdata[0];
                        last_next  = (k_pos == POS_W'(cnt_reg));
                        do_rot     = 1'b1;
                    end
                end
                else if (op_reg == OP_SEARCH && in_list && is_match)
                begin
                    if (!pend_v_reg || slot_free)
                    begin
                        if (pend_v_reg)
                        begin
                            // an earlier match that is now known not to be last
                            out_v_next = 1'b1;
                            sts_next   = STS_FOUND;
                            pos_next   = pend_pos_reg;
                            el_next    = pend_el_reg;
                            last_next  = 1'b0;
                        end
                        pend_v_next   = 1'b1;
                        pend_pos_next = k_pos;
                        pend_el_next  = cdata[0];
                        do_rot        = 1'b1;
                    end
                end
                else
                begin
                    do_rot = 1'b1;
                end

                if (do_rot)
                begin
                    if (k_reg == KW'(DEPTH - 1))
                    begin
                        k_next     = '0;
                        state_next = (op_reg == OP_SEARCH) ? S_FINISH : S_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg + KW'(1);
                    end
                end
            end

            S_FINISH:
            begin
                if (slot_free)
                begin
                    out_v_next  = 1'b1;
                    last_next   = 1'b1;
                    pend_v_next = 1'b0;
                    state_next  = S_IDLE;
                    if (pend_v_reg)
                    begin
                        sts_next = STS_FOUND;
                        pos_next = pend_pos_reg;
                        el_next  = pend_el_reg;
                    end
                    else
                    begin
                        sts_next = STS_NOTFOUND;
                        pos_next = '0;
                        el_next  = '0;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            k_reg        <= '0;
            pend_v_reg   <= 1'b0;
            out_v_reg    <= 1'b0;
            op_reg       <= '0;
            val_reg      <= '0;
            pend_pos_reg <= '0;
            pend_el_reg  <= '0;
            sts_reg      <= '0;
            pos_reg      <= '0;
            el_reg       <= '0;
            last_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            k_reg        <= k_next;
            pend_v_reg   <= pend_v_next;
            out_v_reg    <= out_v_next;
            op_reg       <= op_next;
            val_reg      <= val_next;
            pend_pos_reg <= pend_pos_next;
            pend_el_reg  <= pend_el_next;
            sts_reg      <= sts_next;
            pos_reg      <= pos_next;
            el_reg       <= el_next;
            last_reg     <= last_next;
        end
    end

    // chain of cells: shift moves toward the back, rotate moves toward cell 0
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        assign ctl[i].load  = do_load_back && (cnt_reg[KW-1:0] == KW'(i));
        assign ctl[i].shift = do_shift;
        assign ctl[i].rot   = do_rot;

        bld_cell u_cell (
            .clk       (clk),
            .ctl       (ctl[i]),
            .load_data (val_reg),
            .shift_in  ((i == 0) ? val_reg : cdata[(i + DEPTH - 1) % DEPTH]),
            .rot_in    (cdata[(i + 1) % DEPTH]),
            .data      (cdata[i])
        );
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_v_reg;
    assign status      = sts_reg;
    assign position    = pos_reg;
    assign element     = el_reg;
    assign last_result = last_reg;

    // the count never passes the number of cells
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    // the count holds while the chain rotates
    a_cnt_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |=> $stable(cnt_reg))
        else $error("entry count changed during a scan");

    // only a search reaches the closing step
    a_finish_op: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH) |-> (op_reg == OP_SEARCH))
        else $error("closing step outside a search");

    // every scan ends with the rotation counter back at zero
    a_k_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_SCAN) |-> (k_reg == '0))
        else $error("rotation counter not cleared");

    // a dump never holds a pending match
    a_pend_dump: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && op_reg == OP_DUMP) |-> !pend_v_reg)
        else $error("pending match during a dump");

endmodule

`default_nettype wire

>>> rtl/core/bld_cell.sv
// bld_cell: one storage cell of the deque chain
// depends on bld_pkg for the data width and the cell control word
`timescale 1ns / 1ps
`default_nettype none

module bld_cell
    import bld_pkg::*;
(
    input  wire logic              clk,
    input  wire cell_ctl_t         ctl,
    input  wire logic [DATA_W-1:0] load_data,
    input  wire logic [DATA_W-1:0] shift_in,
    input  wire logic [DATA_W-1:0] rot_in,
    output logic      [DATA_W-1:0] data
);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctl.load)
        begin
            data_next = load_data;
        end
        else if (ctl.shift)
        begin
            data_next = shift_in;
        end
        else if (ctl.rot)
        begin
            data_next = rot_in;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// tb_top: self-checking bench for the bounded deque with linear search
// depends on bld_pkg and bounded_list_deque_with_search_unit
`timescale 1ns / 1ps

module tb_top;
    import bld_pkg::*;

    localparam int DEPTH        = 16;
    localparam int STALL_LIMIT  = 2000;   // cycles with no word moving on either side
    localparam int DRAIN_CYCLES = 3 * DEPTH + 8;

    // one result word as the block should present it
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    position;
        logic [DATA_W-1:0]   element;
        logic                last_result;
    } result_word_t;

    logic                       clk         = 1'b0;
    logic                       rst_n       = 1'b0;
    logic                       in_valid    = 1'b0;
    logic                       in_ready;
    logic        [OPCODE_W-1:0] opcode      = '0;
    logic signed [DATA_W-1:0]   value       = '0;
    logic                       out_valid;
    logic                       out_ready   = 1'b0;
    logic        [STATUS_W-1:0] status;
    logic        [POS_W-1:0]    position;
    logic signed [DATA_W-1:0]   element;
    logic                       last_result;

    // shadow copy of the deque, ring-ordered like the block's logical view
    logic [DATA_W-1:0] shadow_store [DEPTH];
    int                shadow_front = 0;
    int                shadow_count = 0;

    // results still owed by the block, oldest first
    result_word_t      pending_results [$];

    // idle shaping: when set, that side never inserts gaps
    bit                src_no_idle  = 1'b0;
    bit                sink_no_idle = 1'b0;

    int                fail_count    = 0;
    int                words_sent    = 0;
    int                results_seen  = 0;
    int                full_seen     = 0;
    int                empty_seen    = 0;
    int                matches_seen  = 0;
    int                listed_seen   = 0;
    int                idle_cycles   = 0;

    bounded_list_deque_with_search_unit #(
        .DEPTH (DEPTH)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .position    (position),
        .element     (element),
        .last_result (last_result)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // deque predictor
    // ------------------------------------------------------------------

    function automatic void owe_result(input logic [STATUS_W-1:0] sts,
                                       input int pos,
                                       input logic [DATA_W-1:0] elem,
                                       input logic last);
        result_word_t w;
        w.status      = sts;
        w.position    = POS_W'(pos);
        w.element     = elem;
        w.last_result = last;
        pending_results.push_back(w);
    endfunction

    // applies one accepted input word to the shadow deque and queues what it owes
    function automatic void deque_predict(input logic [OPCODE_W-1:0] op,
                                          input logic [DATA_W-1:0] val);
        int           hits;
        int           slot;
        result_word_t tail;
        hits = 0;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (shadow_count == DEPTH)
                    owe_result(STS_FULL, 0, '0, 1'b1);
                else
                begin
                    if (op == OP_PUSH_FRONT)
                    begin
                        // front moves one slot back around the ring
                        shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
                        shadow_store[shadow_front] = val;
                    end
                    else
                        shadow_store[(shadow_front + shadow_count) % DEPTH] = val;
                    shadow_count++;
                    owe_result(STS_DONE, 0, '0, 1'b1);
                end
            end
            OP_POP_BACK:
            begin
                if (shadow_count == 0)
                    owe_result(STS_EMPTY, 0, '0, 1'b1);
                else
                begin
                    shadow_count--;
                    owe_result(STS_DONE, 0, '0, 1'b1);
                end
            end
            OP_SEARCH:
            begin
                if (shadow_count == 0)
                    owe_result(STS_EMPTY, 0, '0, 1'b1);
                else
                begin
                    for (int i = 0; i < shadow_count; i++)
                    begin
                        slot = (shadow_front + i) % DEPTH;
                        if (shadow_store[slot] == val)
                        begin
                            owe_result(STS_FOUND, i + 1, shadow_store[slot], 1'b0);
                            hits++;
                        end
                    end
                    if (hits == 0)
                        owe_result(STS_NOTFOUND, 0, '0, 1'b1);
                    else
                    begin
                        // final match closes the search
                        tail = pending_results.pop_back();
                        tail.last_result = 1'b1;
                        pending_results.push_back(tail);
                    end
                end
            end
            OP_DUMP:
            begin
                if (shadow_count == 0)
                    owe_result(STS_EMPTY, 0, '0, 1'b1);
                else
                    for (int i = 0; i < shadow_count; i++)
                        owe_result(STS_LISTED, i + 1,
                                   shadow_store[(shadow_front + i) % DEPTH],
                                   (i + 1 == shadow_count));
            end
            default:
            begin
                // unused opcodes are swallowed without any result word
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // input side: one word per call, random gap in front of it
    // ------------------------------------------------------------------

    // valid is only dropped when a gap follows, so a back-to-back word keeps it
    // high with a single update in that time step
    task automatic send_word(input logic [OPCODE_W-1:0] op, input logic [DATA_W-1:0] val);
        int gap;
        gap = src_no_idle ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        value    <= val;
        do
            @(posedge clk);
        while (!in_ready);
        deque_predict(op, val);
        words_sent++;
    endtask

    // ------------------------------------------------------------------
    // output side: random stall per word, then compare with the oldest owed
    // ------------------------------------------------------------------

    task automatic check_result_word();
        result_word_t want;
        results_seen++;
        if (pending_results.size() == 0)
        begin
            $error("result word with nothing owed: status %0d position %0d element %h",
                   status, position, element);
            fail_count++;
            return;
        end
        want = pending_results.pop_front();
        if (status !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, status);
            fail_count++;
        end
        if (position !== want.position)
        begin
            $error("position: expected %0d, got %0d", want.position, position);
            fail_count++;
        end
        if (element !== want.element)
        begin
            $error("element: expected %h, got %h", want.element, element);
            fail_count++;
        end
        if (last_result !== want.last_result)
        begin
            $error("last_result: expected %0d, got %0d", want.last_result, last_result);
            fail_count++;
        end
        case (want.status)
            STS_FULL:   full_seen++;
            STS_EMPTY:  empty_seen++;
            STS_FOUND:  matches_seen++;
            STS_LISTED: listed_seen++;
            default:    ;
        endcase
    endtask

    initial
    begin : result_sink
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = sink_no_idle ? 0 : $urandom_range(0, 14);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            check_result_word();
        end
    end

    // watchdog: ends the run when neither side moves a word for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // random word shaping
    // ------------------------------------------------------------------

    // small values collide often so searches hit; extremes and noise mixed in
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return DATA_W'($urandom_range(0, 3));
            2:       return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
        endcase
    endfunction

    // push_pct sets how hard the mix leans toward filling the store
    function automatic logic [OPCODE_W-1:0] pick_opcode(input int push_pct);
        int r;
        if ($urandom_range(0, 99) < push_pct)
            return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        r = $urandom_range(0, 19);
        if (r < 9)
            return OP_POP_BACK;
        if (r < 14)
            return OP_SEARCH;
        if (r < 18)
            return OP_DUMP;
        return OPCODE_W'($urandom_range(5, 7));
    endfunction

    task automatic run_random_words(input int count, input int push_pct);
        for (int n = 0; n < count; n++)
            send_word(pick_opcode(push_pct), pick_value());
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // pop, dump and search on an empty store each report empty
    task automatic test_empty_store();
        send_word(OP_POP_BACK, 32'h0);
        send_word(OP_DUMP, 32'h0);
        send_word(OP_SEARCH, 32'h0);
    endtask

    // unused opcodes leave no trace
    task automatic test_unused_opcodes();
        send_word(3'd5, 32'hFFFF_FFFF);
        send_word(3'd7, 32'h0);
    endtask

    // fill through both ends so the front wraps the ring, then push on full
    task automatic test_fill_to_full();
        logic [DATA_W-1:0] fill_vals [DEPTH];
        fill_vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                      32'h0, 32'h1, 32'h0, 32'h5555_5555,
                      32'hAAAA_AAAA, 32'h0, 32'h8000_0000, 32'h2,
                      32'h7FFF_FFFF, 32'h3, 32'h0, 32'hFFFF_FFFF};
        for (int i = 0; i < DEPTH; i++)
            send_word((i % 2 == 0) ? OP_PUSH_FRONT : OP_PUSH_BACK, fill_vals[i]);
        send_word(OP_PUSH_FRONT, 32'h1234_5678);
        send_word(OP_PUSH_BACK, 32'h1234_5678);
    endtask

    // several matches, a miss, and a full-depth listing
    task automatic test_search_and_dump();
        send_word(OP_SEARCH, 32'h0);
        send_word(OP_SEARCH, 32'h1234_5678);
        send_word(OP_DUMP, 32'h0);
    endtask

    // few pushes, with both sides idling at random: walks the store down
    task automatic test_random_drain();
        src_no_idle  = 1'b0;
        sink_no_idle = 1'b0;
        run_random_words(25, 15);
    endtask

    // balanced mix, input side bursting while the output side stalls, then the reverse
    task automatic test_random_mixed();
        src_no_idle  = 1'b1;
        sink_no_idle = 1'b0;
        run_random_words(15, 45);
        src_no_idle  = 1'b0;
        sink_no_idle = 1'b1;
        run_random_words(10, 45);
    endtask

    // push-heavy with no idling anywhere: refills the store and lists it
    task automatic test_random_fill_back_to_back();
        src_no_idle  = 1'b1;
        sink_no_idle = 1'b1;
        run_random_words(20, 75);
        send_word(OP_DUMP, 32'h0);
    endtask

    initial
    begin
        // reset held low from time zero, released at a rising edge
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_store();
        test_unused_opcodes();
        test_fill_to_full();
        test_search_and_dump();
        test_random_drain();
        test_random_mixed();
        test_random_fill_back_to_back();

        in_valid <= 1'b0;

        // wait for every owed word, then watch for strays
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d result words never arrived", pending_results.size());
            fail_count++;
        end

        $display("run covered %0d input words and %0d result words, %0d mismatches",
                 words_sent, results_seen, fail_count);
        $display("seen: %0d full, %0d empty, %0d matches, %0d listed entries",
                 full_seen, empty_seen, matches_seen, listed_seen);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
